// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the twiddle gain tuner RTL.
// Clocked, reset-qualified implication checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/twg_pkg.sv -----
// Package for the twiddle gain tuner: widths, register indexes, state types
// and the saturating fixed-point helpers. No dependencies.
`timescale 1ns / 1ps

package twg_pkg;

  localparam int GAIN_WIDTH  = 32;
  localparam int ERROR_WIDTH = 48;
  localparam int CFG_WIDTH   = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int NUM_GAINS   = 3;

  localparam int IN_TDATA_W  = ((ERROR_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 * GAIN_WIDTH + 2;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_P = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_I = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_D = 3'd5;

  // Register reset values (Q16.16)
  localparam logic [CFG_WIDTH-1:0] RST_GAIN_P = 32'd65536;
  localparam logic [CFG_WIDTH-1:0] RST_GAIN_I = 32'd0;
  localparam logic [CFG_WIDTH-1:0] RST_GAIN_D = 32'd0;
  localparam logic [CFG_WIDTH-1:0] RST_STEP_P = 32'd6554;
  localparam logic [CFG_WIDTH-1:0] RST_STEP_I = 32'd66;
  localparam logic [CFG_WIDTH-1:0] RST_STEP_D = 32'd6554;

  // 0.8 as a Q0.16 multiplier
  localparam logic [15:0] SHRINK_MUL = 16'd52429;

  localparam logic [1:0] SEL_P    = 2'd0;
  localparam logic [1:0] SEL_LAST = 2'd2;

  typedef enum logic [1:0] {
    PH_INC     = 2'd0,
    PH_DEC     = 2'd1,
    PH_RESTORE = 2'd2
  } phase_t;

  typedef logic [GAIN_WIDTH-1:0]  gain_t;
  typedef logic [ERROR_WIDTH-1:0] err_t;

  typedef struct packed {
    gain_t [NUM_GAINS-1:0] gains;
    gain_t [NUM_GAINS-1:0] steps;
    err_t                  min_error;
    logic [1:0]            sel;
    phase_t                phase;
  } tune_state_t;

  function automatic gain_t sat_add(input gain_t a, input gain_t b);
    logic [GAIN_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[GAIN_WIDTH] ? '1 : sum[GAIN_WIDTH-1:0];
  endfunction

  function automatic gain_t clamp_sub(input gain_t a, input gain_t b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic gain_t step_grow(input gain_t x);
    return sat_add(x, x >> 2);
  endfunction

  // floor(x * 0.8), split as hi*m + (lo*m >> 16)
  function automatic gain_t step_shrink(input gain_t x);
    gain_t       hi_prod;
    logic [31:0] lo_prod;
    hi_prod = (x >> 16) * GAIN_WIDTH'(SHRINK_MUL);
    lo_prod = 32'(x[15:0]) * 32'(SHRINK_MUL);
    return hi_prod + GAIN_WIDTH'(lo_prod[31:16]);
  endfunction

endpackage

// ----- rtl/twg_update.sv -----
// One twiddle step: next search state from the current state and a run error.
// Combinational; uses twg_pkg.
`timescale 1ns / 1ps

module twg_update import twg_pkg::*; (
  input  tune_state_t cur,
  input  err_t        run_error,
  output tune_state_t nxt
);

  logic [1:0] k;
  logic [1:0] k_adv;
  gain_t      g;
  gain_t      s;
  logic       better;

  always_comb begin
    k      = (cur.sel > SEL_LAST) ? SEL_P : cur.sel;
    k_adv  = (k == SEL_LAST) ? SEL_P : k + 2'd1;
    g      = cur.gains[k];
    s      = cur.steps[k];
    better = run_error < cur.min_error;

    nxt     = cur;
    nxt.sel = k;
    case (cur.phase)
      PH_DEC: begin
        if (better) begin
          nxt.min_error = run_error;
          nxt.steps[k]  = step_grow(s);
          nxt.sel       = k_adv;
          nxt.phase     = PH_INC;
        end else begin
          nxt.gains[k] = clamp_sub(clamp_sub(g, s), s);
          nxt.phase    = PH_RESTORE;
        end
      end
      PH_RESTORE: begin
        if (better) begin
          nxt.min_error = run_error;
          nxt.steps[k]  = step_grow(s);
        end else begin
          nxt.gains[k] = sat_add(g, s);
          nxt.steps[k] = step_shrink(s);
        end
        nxt.sel   = k_adv;
        nxt.phase = PH_INC;
      end
      default: begin
        nxt.gains[k] = sat_add(g, s);
        nxt.phase    = PH_DEC;
      end
    endcase
  end

endmodule

// ----- rtl/twiddle_gain_tuner.sv -----
// Twiddle gain tuner: an input beat goes to the input register, then the
// result register. Throughput one beat per cycle while out_tready is high.
// Synchronous active-low reset: gains/steps load register reset values,
// best error goes to all ones, search restarts at P gain, try-increase.
// Depends on twg_pkg, twg_update and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twiddle_gain_tuner import twg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [47:0] run_error
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // gain_p_out, gain_i_out, gain_d_out,
                                             // tuned_index, zero pad
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_WIDTH-1:0]   cfg_wdata
);

  // Input stage
  logic        in_v_r;
  err_t        err_r;
  // Result stage
  logic        out_v_r;
  gain_t [NUM_GAINS-1:0] out_gains_r;
  logic [1:0]  out_sel_r;
  // Search state
  tune_state_t state_r;
  tune_state_t state_nxt;

  logic proc_ok;
  logic fire;

  // The result register frees when empty or drained this cycle, so a new
  // beat can enter each cycle unless a result waits and the input is full.
  assign proc_ok   = !out_v_r || out_tready;
  assign fire      = in_v_r && proc_ok;
  assign in_tready = !in_v_r || proc_ok;

  twg_update u_update (
    .cur       (state_r),
    .run_error (err_r),
    .nxt       (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r                    <= 1'b0;
      out_v_r                   <= 1'b0;
      state_r.gains[0]          <= GAIN_WIDTH'(RST_GAIN_P);
      state_r.gains[1]          <= GAIN_WIDTH'(RST_GAIN_I);
      state_r.gains[2]          <= GAIN_WIDTH'(RST_GAIN_D);
      state_r.steps[0]          <= GAIN_WIDTH'(RST_STEP_P);
      state_r.steps[1]          <= GAIN_WIDTH'(RST_STEP_I);
      state_r.steps[2]          <= GAIN_WIDTH'(RST_STEP_D);
      state_r.min_error         <= '1;
      state_r.sel               <= SEL_P;
      state_r.phase             <= PH_INC;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      // Config loads the live gain/step directly; the user must write only while idle, not enforced.
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_GAIN_P: state_r.gains[0] <= GAIN_WIDTH'(cfg_wdata);
          CFG_GAIN_I: state_r.gains[1] <= GAIN_WIDTH'(cfg_wdata);
          CFG_GAIN_D: state_r.gains[2] <= GAIN_WIDTH'(cfg_wdata);
          CFG_STEP_P: state_r.steps[0] <= GAIN_WIDTH'(cfg_wdata);
          CFG_STEP_I: state_r.steps[1] <= GAIN_WIDTH'(cfg_wdata);
          CFG_STEP_D: state_r.steps[2] <= GAIN_WIDTH'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      err_r <= in_tdata[ERROR_WIDTH-1:0];
    end
    if (fire) begin
      out_gains_r <= state_nxt.gains;
      out_sel_r   <= state_nxt.sel;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({out_sel_r, out_gains_r[2], out_gains_r[1],
                                    out_gains_r[0]});

  // Checks
  `TWG_ASSERT_IMP(a_sel_range, clk, rst_n, 1'b1, state_r.sel <= SEL_LAST, "sel out of range")
  `TWG_ASSERT_NXT(a_fire_out, clk, rst_n, fire, out_v_r, "processed beat lost its result")
  `TWG_ASSERT_NXT(a_inc_to_dec, clk, rst_n, fire && state_r.phase == PH_INC, state_r.phase == PH_DEC, "no inc->dec")
  `TWG_ASSERT_NXT(a_best_mono, clk, rst_n, fire, state_r.min_error <= $past(state_r.min_error), "best error grew")

endmodule

// ----- bench/gain_search_checker.sv -----
// Gain search checker: tracks the twiddle search (gains, steps, best error,
// selected gain, phase) from the observed beats and checks every result beat.
// Depends on twg_pkg.
`timescale 1ns / 1ps

module gain_search_checker import twg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_WIDTH-1:0]   cfg_wdata,
  input  logic                   run_done,
  output int                     fail_count
);

  typedef struct packed {
    gain_t      gain_p;
    gain_t      gain_i;
    gain_t      gain_d;
    logic [1:0] index;
  } gain_set_t;

  gain_t     gain_now [NUM_GAINS];
  gain_t     step_now [NUM_GAINS];
  err_t      best_err;
  logic [1:0] sel_now;
  phase_t    phase_now;

  gain_set_t pending_gains [$];
  int        mismatches = 0;
  bit        leftovers_counted = 1'b0;

  assign fail_count = mismatches;

  // a + b would exceed all ones exactly when a > ~b
  function automatic gain_t capped_add(input gain_t a, input gain_t b);
    return (a > ~b) ? '1 : gain_t'(a + b);
  endfunction

  function automatic gain_t floor_sub(input gain_t a, input gain_t b);
    return (a <= b) ? '0 : gain_t'(a - b);
  endfunction

  function automatic gain_t grown(input gain_t x);
    return capped_add(x, x >> 2);
  endfunction

  // floor(x * 0.8) from the full product
  function automatic gain_t shrunk(input gain_t x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(SHRINK_MUL);
    return gain_t'(prod >> 16);
  endfunction

  function automatic void next_gain();
    sel_now   = (sel_now == SEL_LAST) ? SEL_P : sel_now + 2'd1;
    phase_now = PH_INC;
  endfunction

  function automatic void search_step(input err_t run_err);
    logic [1:0] k;
    logic       improved;
    k        = (sel_now > SEL_LAST) ? SEL_P : sel_now;
    improved = run_err < best_err;
    sel_now  = k;
    case (phase_now)
      PH_DEC: begin
        if (improved) begin
          best_err    = run_err;
          step_now[k] = grown(step_now[k]);
          next_gain();
        end else begin
          gain_now[k] = floor_sub(floor_sub(gain_now[k], step_now[k]), step_now[k]);
          phase_now   = PH_RESTORE;
        end
      end
      PH_RESTORE: begin
        if (improved) begin
          best_err    = run_err;
          step_now[k] = grown(step_now[k]);
        end else begin
          gain_now[k] = capped_add(gain_now[k], step_now[k]);
          step_now[k] = shrunk(step_now[k]);
        end
        next_gain();
      end
      default: begin
        gain_now[k] = capped_add(gain_now[k], step_now[k]);
        phase_now   = PH_DEC;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input gain_t want, input gain_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %08h, got %08h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    gain_set_t want;
    if (!rst_n) begin
      gain_now[0] = RST_GAIN_P;
      gain_now[1] = RST_GAIN_I;
      gain_now[2] = RST_GAIN_D;
      step_now[0] = RST_STEP_P;
      step_now[1] = RST_STEP_I;
      step_now[2] = RST_STEP_D;
      best_err    = '1;
      sel_now     = SEL_P;
      phase_now   = PH_INC;
      pending_gains.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_GAIN_P: gain_now[0] = cfg_wdata;
          CFG_GAIN_I: gain_now[1] = cfg_wdata;
          CFG_GAIN_D: gain_now[2] = cfg_wdata;
          CFG_STEP_P: step_now[0] = cfg_wdata;
          CFG_STEP_I: step_now[1] = cfg_wdata;
          CFG_STEP_D: step_now[2] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        search_step(in_tdata[ERROR_WIDTH-1:0]);
        pending_gains.push_back('{gain_now[0], gain_now[1], gain_now[2], sel_now});
      end
      if (out_tvalid && out_tready) begin
        if (pending_gains.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_tdata);
        end else begin
          want = pending_gains.pop_front();
          check_field("gain_p_out", want.gain_p, out_tdata[31:0]);
          check_field("gain_i_out", want.gain_i, out_tdata[63:32]);
          check_field("gain_d_out", want.gain_d, out_tdata[95:64]);
          check_field("tuned_index", gain_t'(want.index), gain_t'(out_tdata[97:96]));
        end
      end
      if (run_done && !leftovers_counted) begin
        leftovers_counted = 1'b1;
        if (pending_gains.size() != 0) begin
          mismatches += pending_gains.size();
          $display("%0t: %0d results expected, got none", $time, pending_gains.size());
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the twiddle gain tuner bench: clock, reset, stimulus, receiver
// stalls and verdict. Checking lives in gain_search_checker.
// Depends on twg_pkg, gain_search_checker and twiddle_gain_tuner.
`timescale 1ns / 1ps

module testbench;
  import twg_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int CHUNKS       = 6;
  localparam int CHUNK_ITEMS  = 205;
  localparam int HOLD_CHUNK   = 2;       // chunk that gets the long receiver hold
  localparam int LONG_HOLD    = 300;

  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] REG_ORDER [6] = '{
    CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_STEP_P, CFG_STEP_I, CFG_STEP_D
  };

  localparam err_t ERR_WORST = '1;

  // From reset defaults, phase by phase:
  //   P: increase (error ignored, zero), equal-to-best worst error -> decrease,
  //      worst again -> restore and shrink step.
  //   I: increase (ignored), improvement -> step grows.
  //   D: increase (ignored), equal error -> D - 2s clamps at zero,
  //      improvement in the restore phase.
  localparam err_t DIRECTED_A [8] = '{
    48'h0, ERR_WORST, ERR_WORST,
    48'h5555_5555_5555, ERR_WORST - 48'd1,
    48'hAAAA_AAAA_AAAA, ERR_WORST - 48'd1, ERR_WORST - 48'd2
  };

  // After loading saturating registers (gain P all ones, steps near the top):
  //   P: add saturates, improvement -> step growth saturates.
  //   I: 0 + max, equal error -> clamps to zero, worse -> restore, shrink max.
  //   D: add saturates, worse -> double subtraction clamps, improvement.
  localparam err_t DIRECTED_B [8] = '{
    48'h0, ERR_WORST - 48'd3,
    48'h0, ERR_WORST - 48'd3, ERR_WORST,
    48'h0, ERR_WORST, ERR_WORST - 48'd4
  };

  // closing items flip the upper error bits and reach a best error of zero
  localparam err_t TAIL [6] = '{
    48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h0, 48'h0, 48'h0, ERR_WORST
  };

  typedef enum int {PROF_MODEST, PROF_EXTREME, PROF_TINY, PROF_WIDE} cfg_profile_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [47:0] run_error
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] gain_p, [63:32] gain_i, [95:64] gain_d,
                                      // [97:96] tuned_index, zero pad above
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_WIDTH-1:0]   cfg_wdata;

  logic run_done;
  int   failures;
  int   items_sent   = 0;
  int   results_seen = 0;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  bit   hold_request = 1'b0;
  bit   hold_done    = 1'b0;
  err_t err_floor;    // lowest error offered so far, roughly the block's best

  twiddle_gain_tuner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  gain_search_checker gain_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .run_done   (run_done),
    .fail_count (failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Beat counters, used only to know when the block has gone idle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) items_sent <= items_sent + 1;
      if (out_tvalid && out_tready) results_seen <= results_seen + 1;
    end
  end

  // Hard stop in case the handshake locks up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic err_t rand_err();
    return err_t'({$urandom, $urandom});
  endfunction

  // Half the errors improve, so the search keeps moving through all three
  // phases; the rest are ties with the best and worse errors.
  function automatic err_t next_run_error();
    int   roll;
    err_t span;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      if (err_floor != '0) begin
        span      = (err_floor >> 9) + 48'd1;
        err_floor = err_floor - 48'd1 - (rand_err() % span);
      end
      return err_floor;
    end
    if (roll == 5 || err_floor == ERR_WORST) return err_floor;
    return err_floor + 48'd1 + (rand_err() % (ERR_WORST - err_floor));
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_reg(input cfg_profile_t prof,
                                                    input bit is_step);
    case (prof)
      PROF_MODEST:
        return is_step ? $urandom_range(0, 32'h000F_FFFF) : $urandom;
      PROF_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 32'd1;
          2:       return '1;
          3:       return 32'hFFFF_FFFE;
          default: return 32'h8000_0000;
        endcase
      end
      PROF_TINY: return $urandom_range(0, 255);
      default:   return $urandom;
    endcase
  endfunction

  // One beat per call. The sender runs in bursts; between bursts it drops
  // valid for a random gap, sometimes skipping the gap altogether.
  task automatic offer_error(input err_t run_err);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= run_err;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every result is back, then let the block drain before moving on.
  // The first edge lets the beat counters catch up with the last beat.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Rewrites all six registers, plus one write to a spare index with random
  // data that must leave the search alone.
  task automatic load_profile(input cfg_profile_t prof);
    foreach (REG_ORDER[r]) write_reg(REG_ORDER[r], pick_reg(prof, r >= 3));
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: segments of random length, each with its own ready pattern
  // (always open, coin flip, mostly stalled, three-of-four rhythm). Once asked,
  // it closes for a long stretch so the block backs up into the input.
  initial begin
    int       seg_len;
    rx_mode_t mode;
    out_tready <= 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      seg_len = $urandom_range(1, 40);
      mode    = rx_mode_t'($urandom_range(0, 3));
      for (int k = 0; k < seg_len; k++) begin
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ((k % 4) != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = CFG_GAIN_P;
    cfg_wdata = '0;
    run_done  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk from the reset register values
    foreach (DIRECTED_A[j]) offer_error(DIRECTED_A[j]);
    settle();

    // saturating settings, plus both spare indexes
    write_reg(CFG_GAIN_P, '1);
    write_reg(CFG_GAIN_I, '0);
    write_reg(CFG_GAIN_D, 32'h8000_0000);
    write_reg(CFG_STEP_P, '1);
    write_reg(CFG_STEP_I, '1);
    write_reg(CFG_STEP_D, 32'hC000_0000);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED_B[j]) offer_error(DIRECTED_B[j]);

    // best error is now four below all ones; random errors work down from there
    err_floor = ERR_WORST - 48'd4;

    // Random chunks, each under a fresh register setting. Gains and steps are
    // reloaded mid-search: the search position and best error carry over.
    for (int c = 0; c < CHUNKS; c++) begin
      settle();
      load_profile(cfg_profile_t'(c % 4));
      if (c == HOLD_CHUNK) hold_request = 1'b1;
      for (int n = 0; n < CHUNK_ITEMS; n++) offer_error(next_run_error());
    end

    foreach (TAIL[j]) offer_error(TAIL[j]);
    settle();

    // let the checker count leftovers before reading its failure count
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- twiddle_gain_tuner.f -----
+incdir+rtl
rtl/twg_pkg.sv
rtl/twg_update.sv
rtl/twiddle_gain_tuner.sv
bench/gain_search_checker.sv
bench/testbench.sv
